FILE: design/glpd_pkg.sv
// Package with the types, constants and register indexes of the grid line projection detector.
`timescale 1ns / 1ps
`default_nettype none
package glpd_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int CNT_LIMIT  = 4095;

  localparam int CNT_W      = 12;
  localparam int COL_ADDR_W = $clog2(MAX_WIDTH);
  localparam int ROW_NUM_W  = 11;
  localparam int QUERY_W    = 11;
  localparam int DIST_W     = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CNT_W-1:0] COL_CAP =
    CNT_W'(MAX_HEIGHT < CNT_LIMIT ? MAX_HEIGHT : CNT_LIMIT);
  localparam logic [CNT_W-1:0] ROW_CAP =
    CNT_W'(MAX_WIDTH < CNT_LIMIT ? MAX_WIDTH : CNT_LIMIT);
  localparam logic [COL_ADDR_W-1:0] COL_LAST = COL_ADDR_W'(MAX_WIDTH - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_REF_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_SQ   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_MIN   = 3'd5;

  localparam logic OP_PIXEL    = 1'b0;
  localparam logic OP_READ_COL = 1'b1;

  typedef struct packed {
    logic                 opcode;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic                 first_row;
    logic                 end_of_row;
    logic [QUERY_W-1:0]   query_column;
  } glpd_in_t;

  typedef struct packed {
    logic                 is_line_pixel;
    logic                 row_complete;
    logic [ROW_NUM_W-1:0] row_number;
    logic                 row_is_line;
    logic [CNT_W-1:0]     column_count;
    logic                 column_is_line;
  } glpd_out_t;

  typedef struct packed {
    logic [7:0]           ref_red;
    logic [7:0]           ref_green;
    logic [7:0]           ref_blue;
    logic [DIST_W-1:0]    dist_sq_limit;
    logic [CNT_W-1:0]     col_min_count;
    logic [CNT_W-1:0]     row_min_count;
  } glpd_cfg_t;

  typedef struct packed {
    logic                  we;
    logic [COL_ADDR_W-1:0] addr;
    logic [CNT_W-1:0]      data;
  } glpd_mem_wr_t;

endpackage
`default_nettype wire

FILE: design/glpd_cfg_regs.sv
// Configuration register bank of the grid line projection detector.
`timescale 1ns / 1ps
`default_nettype none
module glpd_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [glpd_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [glpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output glpd_pkg::glpd_cfg_t                cfg
);
  import glpd_pkg::*;

  glpd_cfg_t cfg_r;
  glpd_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_REF_RED:   cfg_nxt.ref_red       = cfg_wdata[7:0];
        CFG_REF_GREEN: cfg_nxt.ref_green     = cfg_wdata[7:0];
        CFG_REF_BLUE:  cfg_nxt.ref_blue      = cfg_wdata[7:0];
        CFG_DIST_SQ:   cfg_nxt.dist_sq_limit = cfg_wdata[DIST_W-1:0];
        CFG_COL_MIN:   cfg_nxt.col_min_count = cfg_wdata[CNT_W-1:0];
        CFG_ROW_MIN:   cfg_nxt.row_min_count = cfg_wdata[CNT_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ref_red       <= 8'd149;
      cfg_r.ref_green     <= 8'd149;
      cfg_r.ref_blue      <= 8'd148;
      cfg_r.dist_sq_limit <= DIST_W'(3600);
      cfg_r.col_min_count <= '0;
      cfg_r.row_min_count <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

FILE: design/glpd_color_match.sv
// Squared color distance test that classes a pixel as a grid line pixel.
`timescale 1ns / 1ps
`default_nettype none
module glpd_color_match (
  input  wire glpd_pkg::glpd_in_t  pix,
  input  wire glpd_pkg::glpd_cfg_t cfg,
  output logic                     hit
);
  import glpd_pkg::*;

  logic [7:0]        d_r, d_g, d_b;
  logic [15:0]       sq_r, sq_g, sq_b;
  logic [DIST_W-1:0] dist_sq;

  assign d_r = (pix.red   > cfg.ref_red)   ? pix.red   - cfg.ref_red   : cfg.ref_red   - pix.red;
  assign d_g = (pix.green > cfg.ref_green) ? pix.green - cfg.ref_green
                                           : cfg.ref_green - pix.green;
  assign d_b = (pix.blue  > cfg.ref_blue)  ? pix.blue  - cfg.ref_blue  : cfg.ref_blue  - pix.blue;

  assign sq_r = 16'(d_r) * 16'(d_r);
  assign sq_g = 16'(d_g) * 16'(d_g);
  assign sq_b = 16'(d_b) * 16'(d_b);

  assign dist_sq = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
  assign hit     = dist_sq < cfg.dist_sq_limit;

endmodule
`default_nettype wire

FILE: design/glpd_col_mem.sv
// Column counter memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module glpd_col_mem (
  input  wire logic                            clk,
  input  wire glpd_pkg::glpd_mem_wr_t          wr,
  input  wire logic                            re,
  input  wire logic [glpd_pkg::COL_ADDR_W-1:0] raddr,
  output logic [glpd_pkg::CNT_W-1:0]           rdata
);
  import glpd_pkg::*;

  logic [CNT_W-1:0] mem [MAX_WIDTH];
  logic [CNT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: design/grid_line_projection_detector_unit.sv
// Top level of the grid line projection detector: pipeline, row state and column update.
//
// Pixels enter on the in_ channel in raster order, one beat per pixel, or as
// column read requests (opcode set). Every accepted beat yields exactly one
// result beat on the out_ channel, in order.
// An accepted beat passes the input stage and then the result register. One beat
// is taken every cycle as long as the receiver keeps up; the column counter
// memory is read when a beat is accepted and written when that beat leaves the
// input stage, with a bypass when consecutive beats touch the same column.
// When the receiver stalls, the result register holds its beat and the input
// stage holds the next one; in_ready drops only when both are full.
// Configuration writes on cfg_ take effect at the next clock and must be made
// while no beat is in flight.
// Synchronous reset clears the pipeline, the row hit count and the column and
// row positions and loads the default reference color and limits. The column
// counters need no clearing: pixels of the first row overwrite them.
`timescale 1ns / 1ps
`default_nettype none
module grid_line_projection_detector_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire glpd_pkg::glpd_in_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output glpd_pkg::glpd_out_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [glpd_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [glpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import glpd_pkg::*;

  glpd_cfg_t    cfg;
  glpd_mem_wr_t mem_wr;
  logic [CNT_W-1:0] mem_rdata;

  logic in_acc, s1_adv, out_free;

  logic [COL_ADDR_W-1:0] col_pos_r, col_pos_nxt;
  logic [ROW_NUM_W-1:0]  row_pos_r, row_pos_nxt;
  logic [CNT_W-1:0]      row_cnt_r, row_cnt_nxt;

  logic                  s1_valid_r;
  glpd_in_t              s1_item_r;
  logic [COL_ADDR_W-1:0] s1_addr_r;
  logic [ROW_NUM_W-1:0]  s1_row_num_r;
  logic                  s1_in_range_r;
  logic                  s1_fwd_r;
  logic [CNT_W-1:0]      s1_fwd_val_r;

  logic                  out_valid_r;
  glpd_out_t             out_data_r, out_data_nxt;

  logic [COL_ADDR_W-1:0] rd_addr;
  logic                  rd_in_range;
  logic [ROW_NUM_W-1:0]  cur_row;
  logic                  hit;
  logic [CNT_W-1:0]      old_cnt, new_cnt, row_cnt_now;

  glpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  glpd_color_match u_match (
    .pix (s1_item_r),
    .cfg (cfg),
    .hit (hit)
  );

  glpd_col_mem u_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_acc   = in_valid && in_ready;

  // Input side: address selection and position tracking.
  always_comb begin
    rd_in_range = 1'b1;
    if (in_data.opcode == OP_READ_COL) begin
      rd_addr     = in_data.query_column[COL_ADDR_W-1:0];
      rd_in_range = (32'(in_data.query_column) < MAX_WIDTH);
    end else begin
      rd_addr = col_pos_r;
    end
    cur_row     = in_data.first_row ? '0 : row_pos_r;
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    if (in_acc && in_data.opcode == OP_PIXEL) begin
      if (in_data.end_of_row) begin
        col_pos_nxt = '0;
        row_pos_nxt = cur_row + 1'b1;
      end else begin
        col_pos_nxt = (col_pos_r == COL_LAST) ? '0 : col_pos_r + 1'b1;
        row_pos_nxt = cur_row;
      end
    end
  end

  // Column and row count update for the beat in the input stage.
  always_comb begin
    old_cnt = s1_fwd_r ? s1_fwd_val_r : mem_rdata;
    if (s1_item_r.first_row) begin
      new_cnt = CNT_W'(hit);
    end else if (hit && old_cnt < COL_CAP) begin
      new_cnt = old_cnt + 1'b1;
    end else begin
      new_cnt = old_cnt;
    end
    if (new_cnt > COL_CAP) begin
      new_cnt = COL_CAP;
    end

    row_cnt_now = (hit && row_cnt_r < ROW_CAP) ? row_cnt_r + 1'b1 : row_cnt_r;

    mem_wr.we   = s1_adv && (s1_item_r.opcode == OP_PIXEL);
    mem_wr.addr = s1_addr_r;
    mem_wr.data = new_cnt;

    row_cnt_nxt = row_cnt_r;
    if (mem_wr.we) begin
      row_cnt_nxt = s1_item_r.end_of_row ? '0 : row_cnt_now;
    end

    out_data_nxt = '0;
    if (s1_item_r.opcode == OP_READ_COL) begin
      if (s1_in_range_r) begin
        out_data_nxt.column_count   = old_cnt;
        out_data_nxt.column_is_line = old_cnt >= cfg.col_min_count;
      end
    end else begin
      out_data_nxt.is_line_pixel  = hit;
      out_data_nxt.row_complete   = s1_item_r.end_of_row;
      out_data_nxt.column_count   = new_cnt;
      out_data_nxt.column_is_line = new_cnt >= cfg.col_min_count;
      if (s1_item_r.end_of_row) begin
        out_data_nxt.row_number  = s1_row_num_r;
        out_data_nxt.row_is_line = row_cnt_now >= cfg.row_min_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r   <= '0;
      row_pos_r   <= '0;
      row_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
      row_cnt_r <= row_cnt_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The memory returns the old value when it is written and read in the same cycle.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r     <= in_data;
      s1_addr_r     <= rd_addr;
      s1_row_num_r  <= cur_row;
      s1_in_range_r <= rd_in_range;
      s1_fwd_r      <= mem_wr.we && (mem_wr.addr == rd_addr);
      s1_fwd_val_r  <= mem_wr.data;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the grid line projection detector: directed, long-run and random beats.
`timescale 1ns / 1ps
module tb_top;
  import glpd_pkg::*;

  localparam int DIST_SQ_MAX = 195076;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES      = 4;
  localparam int PHASE_BEATS = 30;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  glpd_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  glpd_out_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow of the block: register settings, column counters and row state.
  glpd_cfg_t             cur_cfg;
  logic [CNT_W-1:0]      col_hits [MAX_WIDTH];
  bit                    col_loaded [MAX_WIDTH];
  logic [CNT_W-1:0]      row_hits;
  logic [ROW_NUM_W-1:0]  row_idx;
  int                    col_idx;

  glpd_out_t             pending_results [$];
  int                    mismatches      = 0;
  int                    beats_sent      = 0;
  int                    results_checked = 0;
  int                    settings_seen   = 0;
  int                    quiet_cycles    = 0;
  int                    sink_hold_req   = 0;
  bit                    src_idle_on     = 1'b1;
  bit                    sink_idle_on    = 1'b1;

  grid_line_projection_detector_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic glpd_cfg_t make_settings(input int r, g, b, lim, col_min, row_min);
    glpd_cfg_t c;
    c.ref_red       = 8'(r);
    c.ref_green     = 8'(g);
    c.ref_blue      = 8'(b);
    c.dist_sq_limit = DIST_W'(lim);
    c.col_min_count = CNT_W'(col_min);
    c.row_min_count = CNT_W'(row_min);
    return c;
  endfunction

  function automatic glpd_out_t project_pixel(input glpd_in_t beat);
    glpd_out_t        res;
    logic [CNT_W-1:0] cnt;
    int               dr, dg, db;
    logic             hit;
    res = '0;
    if (beat.opcode == OP_READ_COL) begin
      if (int'(beat.query_column) < MAX_WIDTH) begin
        res.column_count   = col_hits[beat.query_column];
        res.column_is_line = (res.column_count >= cur_cfg.col_min_count);
      end
      return res;
    end
    dr  = int'(beat.red) - int'(cur_cfg.ref_red);
    dg  = int'(beat.green) - int'(cur_cfg.ref_green);
    db  = int'(beat.blue) - int'(cur_cfg.ref_blue);
    hit = (dr * dr + dg * dg + db * db) < int'(cur_cfg.dist_sq_limit);
    if (beat.first_row) begin
      cnt     = CNT_W'(hit);
      row_idx = '0;
    end else begin
      cnt = col_hits[col_idx];
      if (hit && cnt < COL_CAP) cnt = cnt + 1'b1;
    end
    if (cnt > COL_CAP) cnt = COL_CAP;
    col_hits[col_idx]   = cnt;
    col_loaded[col_idx] = 1'b1;
    if (hit && row_hits < ROW_CAP) row_hits = row_hits + 1'b1;
    res.is_line_pixel  = hit;
    res.row_complete   = beat.end_of_row;
    res.column_count   = cnt;
    res.column_is_line = (cnt >= cur_cfg.col_min_count);
    if (beat.end_of_row) begin
      res.row_number  = row_idx;
      res.row_is_line = (row_hits >= cur_cfg.row_min_count);
      row_hits        = '0;
      col_idx         = 0;
      row_idx         = row_idx + 1'b1;
    end else begin
      col_idx = (col_idx + 1) % MAX_WIDTH;
    end
    return res;
  endfunction

  function automatic logic [7:0] near_level(input logic [7:0] center);
    int v;
    v = int'(center) + int'($urandom_range(0, 120)) - 60;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic logic [QUERY_W-1:0] random_loaded_column();
    logic [QUERY_W-1:0] col;
    col = QUERY_W'($urandom());
    if (!col_loaded[col]) col = '0;
    return col;
  endfunction

  function automatic glpd_cfg_t random_settings();
    glpd_cfg_t c;
    c.ref_red   = 8'($urandom());
    c.ref_green = 8'($urandom());
    c.ref_blue  = 8'($urandom());
    case ($urandom_range(0, 5))
      0: c.dist_sq_limit = '0;
      1: c.dist_sq_limit = DIST_W'(1);
      2: c.dist_sq_limit = DIST_W'(3600);
      3: c.dist_sq_limit = DIST_W'(DIST_SQ_MAX);
      4: c.dist_sq_limit = DIST_W'($urandom_range(0, DIST_SQ_MAX));
      default: c.dist_sq_limit = DIST_W'($urandom_range(200, 8000));
    endcase
    c.col_min_count = ($urandom_range(0, 7) == 0) ? CNT_W'(MAX_HEIGHT)
                                                  : CNT_W'($urandom_range(0, 6));
    c.row_min_count = ($urandom_range(0, 7) == 0) ? CNT_W'(MAX_WIDTH)
                                                  : CNT_W'($urandom_range(0, 12));
    return c;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  task automatic send_beat(input glpd_in_t beat);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_results = {pending_results, project_pixel(beat)};
    beats_sent++;
  endtask

  task automatic send_pixel(input logic [7:0] r, g, b, input logic first, eor);
    glpd_in_t beat;
    beat.opcode       = OP_PIXEL;
    beat.red          = r;
    beat.green        = g;
    beat.blue         = b;
    // A column that was never loaded may only be reached by a first-row pixel.
    beat.first_row    = first || !col_loaded[col_idx];
    beat.end_of_row   = eor;
    beat.query_column = QUERY_W'($urandom());
    send_beat(beat);
  endtask

  task automatic send_random_pixel(input logic first, eor);
    if ($urandom_range(0, 1) == 1)
      send_pixel(near_level(cur_cfg.ref_red), near_level(cur_cfg.ref_green),
                 near_level(cur_cfg.ref_blue), first, eor);
    else
      send_pixel(8'($urandom()), 8'($urandom()), 8'($urandom()), first, eor);
  endtask

  task automatic send_query(input logic [QUERY_W-1:0] col);
    glpd_in_t beat;
    beat.opcode       = OP_READ_COL;
    beat.red          = 8'($urandom());
    beat.green        = 8'($urandom());
    beat.blue         = 8'($urandom());
    beat.first_row    = 1'($urandom());
    beat.end_of_row   = 1'($urandom());
    beat.query_column = col;
    send_beat(beat);
  endtask

  task automatic close_open_row();
    if (col_idx != 0) send_random_pixel(1'b0, 1'b1);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic program_regs(input glpd_cfg_t c);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_REF_RED;
    cfg_wdata <= CFG_DATA_W'(c.ref_red);
    @(posedge clk);
    cfg_addr  <= CFG_REF_GREEN;
    cfg_wdata <= CFG_DATA_W'(c.ref_green);
    @(posedge clk);
    cfg_addr  <= CFG_REF_BLUE;
    cfg_wdata <= CFG_DATA_W'(c.ref_blue);
    @(posedge clk);
    cfg_addr  <= CFG_DIST_SQ;
    cfg_wdata <= CFG_DATA_W'(c.dist_sq_limit);
    @(posedge clk);
    cfg_addr  <= CFG_COL_MIN;
    cfg_wdata <= CFG_DATA_W'(c.col_min_count);
    @(posedge clk);
    cfg_addr  <= CFG_ROW_MIN;
    cfg_wdata <= CFG_DATA_W'(c.row_min_count);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_cfg = c;
    settings_seen++;
  endtask

  task automatic send_random_frame();
    int w, h, r, c;
    w = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 160) : $urandom_range(1, 20);
    h = $urandom_range(1, 8);
    close_open_row();
    for (r = 0; r < h; r++) begin
      for (c = 0; c < w; c++) begin
        if ($urandom_range(0, 11) == 0) send_query(random_loaded_column());
        send_random_pixel(r == 0, c == w - 1);
      end
    end
  endtask

  task automatic send_noise(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 2) == 0)
        send_query(random_loaded_column());
      else
        send_random_pixel($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic test_directed();
    int c;
    send_pixel(8'd149, 8'd149, 8'd148, 1'b1, 1'b0);
    send_pixel(8'd209, 8'd149, 8'd148, 1'b1, 1'b0);
    send_pixel(8'd90, 8'd149, 8'd148, 1'b1, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
    for (c = 0; c < 5; c++) send_pixel(8'd149, 8'd149, 8'd148, 1'b0, c == 4);
    for (c = 0; c < 5; c++) send_query(QUERY_W'(c));
    send_pixel(8'd149, 8'd149, 8'd148, 1'b0, 1'b0);
    // A first-row pixel in the middle of a frame restarts the row number at zero.
    send_pixel(8'd149, 8'd149, 8'd148, 1'b1, 1'b1);
  endtask

  task automatic test_register_extremes();
    close_open_row();
    wait_results_drained();
    program_regs(make_settings(0, 0, 0, DIST_SQ_MAX, MAX_HEIGHT, MAX_WIDTH));
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b1);
    wait_results_drained();
    program_regs(make_settings(255, 255, 255, 0, 0, 0));
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
    wait_results_drained();
    program_regs(make_settings(255, 255, 255, 1, 0, 0));
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
    send_pixel(8'd254, 8'd255, 8'd255, 1'b0, 1'b1);
  endtask

  task automatic test_tall_column();
    int r;
    close_open_row();
    wait_results_drained();
    program_regs(make_settings(149, 149, 148, DIST_SQ_MAX, MAX_HEIGHT, 1));
    // One-pixel rows drive column zero into saturation and wrap the row number.
    for (r = 0; r < MAX_HEIGHT + 2; r++) begin
      if (r == 700) sink_hold_req = 400;
      send_random_pixel(r == 0, 1'b1);
    end
    send_query(QUERY_W'(0));
  endtask

  task automatic test_random();
    int phase, stop_at, pick;
    for (phase = 0; phase < PHASES; phase++) begin
      wait_results_drained();
      program_regs(random_settings());
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      stop_at = beats_sent + PHASE_BEATS;
      while (beats_sent < stop_at) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          send_random_frame();
        end else if (pick < 90) begin
          send_noise($urandom_range(1, 8));
        end else if (pick < 95) begin
          wait_results_drained();
        end else begin
          sink_hold_req = $urandom_range(100, 400);
          send_random_frame();
        end
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      if (sink_hold_req > 0) begin
        stall = sink_hold_req;
        sink_hold_req = 0;
      end else begin
        stall = sink_idle_on ? $urandom_range(0, 14) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin : result_check
    glpd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat arrived with nothing expected");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("is_line_pixel", want.is_line_pixel, out_data.is_line_pixel);
        check_field("row_complete", want.row_complete, out_data.row_complete);
        check_field("row_number", want.row_number, out_data.row_number);
        check_field("row_is_line", want.row_is_line, out_data.row_is_line);
        check_field("column_count", want.column_count, out_data.column_count);
        check_field("column_is_line", want.column_is_line, out_data.column_is_line);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles.", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : main_sequence
    int i;
    cur_cfg  = make_settings(149, 149, 148, 3600, 0, 0);
    row_hits = '0;
    row_idx  = '0;
    col_idx  = 0;
    for (i = 0; i < MAX_WIDTH; i++) begin
      col_hits[i]   = '0;
      col_loaded[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_extremes();
    test_tall_column();
    test_random();
    wait_results_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d pixel and column-read beats, checked %0d results, %0d register settings.",
             beats_sent, results_checked, settings_seen);
    $display("Covered color limits, counter saturation, wraps and back-pressure stalls.");
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
